// ===== sv/pps_pkg.sv =====
// ---------------------------------------------------------------------------
// Pin program sequencer package
// Shared types and constants: item modes, opcodes, pin actions and the
// layout of a program word on its way into the program store.
// ---------------------------------------------------------------------------
package pps_pkg;

  // Default number of program words.
  localparam int unsigned ProgramDepthDef = 256;

  // What an input item asks for.
  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_TICK  = 2'd1,
    MODE_KILL  = 2'd2,
    MODE_PAUSE = 2'd3
  } mode_e;

  // Instruction opcodes; the remaining code is treated as unknown.
  typedef enum logic [2:0] {
    OP_TOGGLE = 3'd0,
    OP_WRITE  = 3'd1,
    OP_DELAY  = 3'd2,
    OP_LOG    = 3'd3,
    OP_JUMP   = 3'd4,
    OP_STORE  = 3'd5,
    OP_HALT   = 3'd6
  } opcode_e;

  // Pin action reported with a result item.
  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_TOGGLE = 2'd1,
    ACT_WRITE  = 2'd2
  } pin_action_e;

  // A program word travelling through the load pipeline.
  typedef struct packed {
    logic [7:0]  addr;
    logic [2:0]  opcode;
    logic [2:0]  port;
    logic [15:0] mask;
    logic        level;
    logic [31:0] argument;
  } load_word_t;

endpackage

// ===== sv/pps_ram.sv =====
// ---------------------------------------------------------------------------
// Pin program sequencer RAM
// Generic single-port-write, single-port-read memory with a registered read.
// ---------------------------------------------------------------------------
module pps_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/pin_program_sequencer.sv =====
// ---------------------------------------------------------------------------
// Pin program sequencer
// Runs a small stored program of pin toggles, writes, delays and jumps, at
// most one instruction per tick item, and reports one result per input item.
// ---------------------------------------------------------------------------
// For a tick item, the program word at the counter is read from the program
// store when the item is accepted, and the instruction executes in the
// execute stage, where it sets the address of the next read. A load item's
// word passes a three-stage pipeline that reduces its argument modulo the
// program depth (reciprocal multiply, back-multiply, one correction) before
// it is written; no item is accepted while a load is in that pipeline.
// Results leave through an output register, so the next item is taken while
// a result still waits.
module pin_program_sequencer
  import pps_pkg::*;
#(
  parameter int unsigned ProgramDepth = pps_pkg::ProgramDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  load_address_i,
  input  logic [2:0]  load_opcode_i,
  input  logic [2:0]  load_port_i,
  input  logic [15:0] load_pin_mask_i,
  input  logic        load_level_i,
  input  logic [31:0] load_argument_i,
  // Result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  pin_action_o,
  output logic [2:0]  pin_port_o,
  output logic [15:0] pin_mask_o,
  output logic        pin_level_o,
  output logic        log_valid_o,
  output logic [7:0]  log_counter_o,
  output logic [7:0]  log_shutdown_o,
  output logic        running_o,
  output logic        led_off_o,
  output logic [7:0]  current_counter_o
);

  localparam int unsigned AddrW = $clog2(ProgramDepth);
  localparam int unsigned WordW = 55 + AddrW;
  // Reciprocal of the depth for the modulo reduction of jump and store targets.
  localparam logic [63:0] RecipFull = (64'd1 << 32) / 64'(ProgramDepth);
  localparam logic [31:0] Recip = RecipFull[31:0];
  localparam logic [31:0] DepthW = 32'(ProgramDepth);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(ProgramDepth - 1);

  // Handshakes.
  logic in_acc;
  logic exec_go;

  // Execute stage.
  logic  exec_vld_q;
  mode_e exec_mode_q;

  // Load pipeline.
  logic       ld1_vld_q, ld2_vld_q, ld3_vld_q;
  load_word_t ld1_q, ld2_q, ld3_q;
  logic [31:0] qest_q;
  logic [31:0] prod_q;
  logic [63:0] recip_prod;
  logic [31:0] rem_raw;
  logic [31:0] rem_fix;
  logic        addr_ok;

  // Program store.
  logic             ram_we;
  logic [WordW-1:0] ram_wdata;
  logic             ram_re;
  logic [WordW-1:0] ram_rdata;

  // Fields of the word read for a tick.
  opcode_e          rd_opcode;
  logic [2:0]       rd_port;
  logic [15:0]      rd_mask;
  logic             rd_level;
  logic [31:0]      rd_argument;
  logic [AddrW-1:0] rd_target;

  // Sequencer state.
  logic [AddrW-1:0] counter_q, counter_d;
  logic [AddrW-1:0] shutdown_q, shutdown_d;
  logic [31:0]      delay_left_q, delay_left_d;
  logic             delay_active_q, delay_active_d;
  logic             kill_q, kill_d;
  logic             pause_q, pause_d;
  logic             run_q, run_d;
  logic [31:0]      delay_dec;
  logic [AddrW-1:0] counter_inc;

  // Result register.
  logic        out_vld_q;
  pin_action_e act_d, act_q;
  logic [2:0]  port_d, port_q;
  logic [15:0] mask_d, mask_q;
  logic        level_d, level_q;
  logic        logv_d, logv_q;
  logic [7:0]  logc_d, logc_q;
  logic [7:0]  logs_d, logs_q;
  logic        led_d, led_q;
  logic        run_out_q;
  logic [7:0]  cur_q;

  // Accept control: a tick in execution sets the next read address, and a
  // load in flight must land before any later tick reads the store.
  assign exec_go    = exec_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = (exec_vld_q && ((exec_mode_q == MODE_TICK) || !exec_go)) ||
                      ld1_vld_q || ld2_vld_q || ld3_vld_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign addr_ok    = {24'd0, load_address_i} < DepthW;

  // Execute stage register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exec_vld_q <= 1'b0;
    end else if (in_acc) begin
      exec_vld_q <= 1'b1;
    end else if (exec_go) begin
      exec_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      exec_mode_q <= mode_e'(mode_i);
    end
  end

  // Load pipeline valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ld1_vld_q <= 1'b0;
      ld2_vld_q <= 1'b0;
      ld3_vld_q <= 1'b0;
    end else begin
      ld1_vld_q <= in_acc && (mode_e'(mode_i) == MODE_LOAD) && addr_ok;
      ld2_vld_q <= ld1_vld_q;
      ld3_vld_q <= ld2_vld_q;
    end
  end

  // Load pipeline payload: quotient estimate, back-multiply, correction.
  assign recip_prod = 64'(ld1_q.argument) * 64'(Recip);

  always_ff @(posedge clk_i) begin
    ld1_q.addr     <= load_address_i;
    ld1_q.opcode   <= load_opcode_i;
    ld1_q.port     <= load_port_i;
    ld1_q.mask     <= load_pin_mask_i;
    ld1_q.level    <= load_level_i;
    ld1_q.argument <= load_argument_i;
    ld2_q          <= ld1_q;
    qest_q         <= recip_prod[63:32];
    ld3_q          <= ld2_q;
    prod_q         <= 32'(qest_q * DepthW);
  end

  assign rem_raw   = ld3_q.argument - prod_q;
  assign rem_fix   = (rem_raw >= DepthW) ? rem_raw - DepthW : rem_raw;
  assign ram_we    = ld3_vld_q;
  assign ram_wdata = {AddrW'(rem_fix), ld3_q.argument, ld3_q.level, ld3_q.mask,
                      ld3_q.port, ld3_q.opcode};
  assign ram_re    = in_acc && (mode_e'(mode_i) == MODE_TICK);

  pps_ram #(
    .Width (WordW),
    .Depth (ProgramDepth)
  ) u_program_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AddrW'(ld3_q.addr)),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (counter_q),
    .rdata_o (ram_rdata)
  );

  // Unpack the word read for the current tick.
  assign rd_opcode   = opcode_e'(ram_rdata[2:0]);
  assign rd_port     = ram_rdata[5:3];
  assign rd_mask     = ram_rdata[21:6];
  assign rd_level    = ram_rdata[22];
  assign rd_argument = ram_rdata[54:23];
  assign rd_target   = ram_rdata[WordW-1:55];

  assign delay_dec   = delay_left_q - 32'd1;
  assign counter_inc = (counter_q == LastAddr) ? '0 : counter_q + AddrW'(1);

  // Execution of one item: state update and result fields.
  always_comb begin
    counter_d      = counter_q;
    shutdown_d     = shutdown_q;
    delay_left_d   = delay_left_q;
    delay_active_d = delay_active_q;
    kill_d         = kill_q;
    pause_d        = pause_q;
    run_d          = run_q;
    act_d          = ACT_NONE;
    port_d         = '0;
    mask_d         = '0;
    level_d        = 1'b0;
    logv_d         = 1'b0;
    logc_d         = '0;
    logs_d         = '0;
    led_d          = 1'b0;
    unique case (exec_mode_q)
      MODE_LOAD: begin
      end
      MODE_KILL: begin
        kill_d = 1'b1;
      end
      MODE_PAUSE: begin
        pause_d = 1'b1;
      end
      MODE_TICK: begin
        if (!run_q) begin
          // Stopped: nothing happens.
        end else if (kill_q) begin
          run_d          = 1'b0;
          delay_active_d = 1'b0;
          delay_left_d   = '0;
          led_d          = 1'b1;
        end else if (delay_active_q) begin
          if (pause_q) begin
            pause_d        = 1'b0;
            delay_active_d = 1'b0;
            delay_left_d   = '0;
            counter_d      = shutdown_q;
          end else begin
            delay_left_d = delay_dec;
            if (delay_dec == '0) begin
              delay_active_d = 1'b0;
              counter_d      = counter_inc;
            end
          end
        end else begin
          unique case (rd_opcode)
            OP_TOGGLE: begin
              act_d     = ACT_TOGGLE;
              port_d    = rd_port;
              mask_d    = rd_mask;
              counter_d = counter_inc;
            end
            OP_WRITE: begin
              act_d     = ACT_WRITE;
              port_d    = rd_port;
              mask_d    = rd_mask;
              level_d   = rd_level;
              counter_d = counter_inc;
            end
            OP_DELAY: begin
              if (pause_q) begin
                pause_d   = 1'b0;
                counter_d = shutdown_q;
              end else if (rd_argument == '0) begin
                counter_d = counter_inc;
              end else begin
                delay_active_d = 1'b1;
                delay_left_d   = rd_argument;
              end
            end
            OP_LOG: begin
              logv_d    = 1'b1;
              logc_d    = 8'(counter_q);
              logs_d    = 8'(shutdown_q);
              counter_d = counter_inc;
            end
            OP_JUMP: begin
              counter_d = rd_target;
            end
            OP_STORE: begin
              shutdown_d = rd_target;
              counter_d  = counter_inc;
            end
            OP_HALT: begin
              run_d          = 1'b0;
              delay_active_d = 1'b0;
              delay_left_d   = '0;
              led_d          = 1'b1;
            end
            default: begin
              // Unknown opcode: the counter stays.
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counter_q      <= '0;
      shutdown_q     <= '0;
      delay_left_q   <= '0;
      delay_active_q <= 1'b0;
      kill_q         <= 1'b0;
      pause_q        <= 1'b0;
      run_q          <= 1'b1;
    end else if (exec_go) begin
      counter_q      <= counter_d;
      shutdown_q     <= shutdown_d;
      delay_left_q   <= delay_left_d;
      delay_active_q <= delay_active_d;
      kill_q         <= kill_d;
      pause_q        <= pause_d;
      run_q          <= run_d;
    end
  end

  // Result register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (exec_go) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (exec_go) begin
      act_q     <= act_d;
      port_q    <= port_d;
      mask_q    <= mask_d;
      level_q   <= level_d;
      logv_q    <= logv_d;
      logc_q    <= logc_d;
      logs_q    <= logs_d;
      led_q     <= led_d;
      run_out_q <= run_d;
      cur_q     <= 8'(counter_d);
    end
  end

  assign out_valid_o       = out_vld_q;
  assign pin_action_o      = act_q;
  assign pin_port_o        = port_q;
  assign pin_mask_o        = mask_q;
  assign pin_level_o       = level_q;
  assign log_valid_o       = logv_q;
  assign log_counter_o     = logc_q;
  assign log_shutdown_o    = logs_q;
  assign running_o         = run_out_q;
  assign led_off_o         = led_q;
  assign current_counter_o = cur_q;

endmodule
